// File: hw/rtl/tjp_pkg.sv
// Shared types, field widths, codes and constants of the three-joint PID/PWM block.
// No dependencies; every other file of the block depends on this package.
package tjp_pkg;

	localparam int JOINT_CNT     = 3;
	localparam int SUM_WIDTH_DEF = 48;

	localparam int MODE_W    = 2;
	localparam int VAL_W     = 20;
	localparam int ANGLE_W   = 21;
	localparam int ERR_W     = 22;
	localparam int DIFF_W    = 23;
	localparam int GAIN_W    = 20;
	localparam int PWM_W     = 16;
	localparam int REG_W     = 60;
	localparam int CFG_IDX_W = 2;
	localparam int XW        = 32;

	typedef logic [MODE_W-1:0]           mode_t;
	typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
	typedef logic signed [VAL_W-1:0]     value_t;
	typedef logic signed [GAIN_W-1:0]    gain_t;
	typedef logic [PWM_W-1:0]            pwm_t;
	typedef logic [REG_W-1:0]            gain_reg_t;

	localparam mode_t MODE_ENC  = 2'd0;
	localparam mode_t MODE_REF  = 2'd1;
	localparam mode_t MODE_TICK = 2'd2;

	localparam cfg_idx_t CFG_PROP  = 2'd0;
	localparam cfg_idx_t CFG_INTEG = 2'd1;
	localparam cfg_idx_t CFG_DERIV = 2'd2;

	// kp = -2.0 base, -6.0 shoulder, -0.5 elbow
	localparam gain_reg_t PROP_GAINS_RST = 60'hFFF80FFA00FFE00;

	// count * 256 * num / den reduced to count * MUL / DIV, rounding term HALF
	localparam int unsigned SCALE_MUL_TAB [JOINT_CNT] = '{2304, 192, 4608};
	localparam int unsigned SCALE_DIV_TAB [JOINT_CNT] = '{101, 13, 215};
	localparam int unsigned SCALE_HALF_TAB[JOINT_CNT] = '{50, 6, 107};

	localparam int ANGLE_MAX = 1048575;
	localparam int ANGLE_NEG = 1048576;
	localparam int TERM_LOG  = 44;
	localparam int OUT_LIM   = 240 * 65536;
	localparam int PWM_OFS   = OUT_LIM + 256;
	localparam int PWM_SHIFT = 9;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic upd_enc;
		logic upd_ref;
		logic upd_tick;
		logic ld4;
		logic ld5;
		logic ld_out;
	} ctl_t;

endpackage

// File: hw/rtl/tjp_if.sv
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on tjp_pkg for field types.
interface tjp_in_if;
	logic                valid;
	logic                ready;
	tjp_pkg::mode_t      mode;
	tjp_pkg::value_t     value_base;
	tjp_pkg::value_t     value_shoulder;
	tjp_pkg::value_t     value_elbow;

	modport source(output valid, mode, value_base, value_shoulder, value_elbow, input ready);
	modport sink(input valid, mode, value_base, value_shoulder, value_elbow, output ready);
endinterface

interface tjp_out_if;
	logic                          valid;
	logic                          ready;
	tjp_pkg::pwm_t                 pwm_base;
	tjp_pkg::pwm_t                 pwm_shoulder;
	tjp_pkg::pwm_t                 pwm_elbow;
	logic [tjp_pkg::JOINT_CNT-1:0] clamp_flags;

	modport source(output valid, pwm_base, pwm_shoulder, pwm_elbow, clamp_flags, input ready);
	modport sink(input valid, pwm_base, pwm_shoulder, pwm_elbow, clamp_flags, output ready);
endinterface

interface tjp_cfg_if;
	logic                  valid;
	logic                  ready;
	tjp_pkg::cfg_idx_t     index;
	tjp_pkg::gain_reg_t    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/tjp_flow.sv
// Stage valid tracking and load enables for the joint lanes and the result register.
// Depends on tjp_pkg (mode codes, ctl_t).
module tjp_flow (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tjp_pkg::mode_t  in_mode,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output tjp_pkg::ctl_t   ctl
);
	import tjp_pkg::*;

	logic  v1_q, v2_q, v3_q, v4_q, v5_q, ov_q;
	mode_t mode_s1, mode_s2;
	logic  rdy1, rdy2, rdy3, rdy4, rdy5;
	logic  ld1, ld2, ld3, ld4, ld5, ld_o, go2, tick2;

	assign ld_o  = v5_q && (!ov_q || out_ready);
	assign rdy5  = !v5_q || ld_o;
	assign ld5   = v4_q && rdy5;
	assign rdy4  = !v4_q || ld5;
	assign ld4   = v3_q && rdy4;
	assign rdy3  = !v3_q || ld4;
	assign tick2 = (mode_s2 == MODE_TICK);
	assign go2   = v2_q && (!tick2 || rdy3);
	assign ld3   = go2 && tick2;
	assign rdy2  = !v2_q || go2;
	assign ld2   = v1_q && rdy2;
	assign rdy1  = !v1_q || ld2;
	assign ld1   = in_valid && rdy1;

	assign in_ready  = rdy1;
	assign out_valid = ov_q;

	assign ctl.ld1      = ld1;
	assign ctl.ld2      = ld2;
	assign ctl.upd_enc  = go2 && (mode_s2 == MODE_ENC);
	assign ctl.upd_ref  = go2 && (mode_s2 == MODE_REF);
	assign ctl.upd_tick = ld3;
	assign ctl.ld4      = ld4;
	assign ctl.ld5      = ld5;
	assign ctl.ld_out   = ld_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			v1_q <= ld1 || (v1_q && !ld2);
			v2_q <= ld2 || (v2_q && !go2);
			v3_q <= ld3 || (v3_q && !ld4);
			v4_q <= ld4 || (v4_q && !ld5);
			v5_q <= ld5 || (v5_q && !ld_o);
			ov_q <= ld_o || (ov_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			mode_s1 <= in_mode;
		end
		if (ld2) begin
			mode_s2 <= mode_s1;
		end
	end

endmodule

// File: hw/rtl/tjp_lane.sv
// One joint lane: encoder scaling by reciprocal multiply, joint state, PID terms,
// clamp and PWM mapping. Depends on tjp_pkg; load enables come from tjp_flow.
module tjp_lane #(
	parameter int          SUM_WIDTH  = tjp_pkg::SUM_WIDTH_DEF,
	parameter int unsigned SCALE_MUL  = tjp_pkg::SCALE_MUL_TAB[0],
	parameter int unsigned SCALE_DIV  = tjp_pkg::SCALE_DIV_TAB[0],
	parameter int unsigned SCALE_HALF = tjp_pkg::SCALE_HALF_TAB[0]
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tjp_pkg::ctl_t    ctl,
	input  tjp_pkg::value_t  value,
	input  tjp_pkg::gain_t   kp,
	input  tjp_pkg::gain_t   ki,
	input  tjp_pkg::gain_t   kd,
	output tjp_pkg::pwm_t    pwm,
	output logic             clamp
);
	import tjp_pkg::*;

	localparam int SH     = XW + $clog2(SCALE_DIV);
	localparam int PROD_W = 2 * XW + 1;
	localparam logic [XW:0] RECIP_C =
		(XW + 1)'(((64'd1 << SH) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));
	localparam logic [XW-1:0] MUL_C  = XW'(SCALE_MUL);
	localparam logic [XW-1:0] HALF_C = XW'(SCALE_HALF);
	localparam logic [XW-1:0] QPOS_C = XW'(ANGLE_MAX);
	localparam logic [XW-1:0] QNEG_C = XW'(ANGLE_NEG);

	localparam int MAGW   = (SUM_WIDTH > TERM_LOG + 1) ? SUM_WIDTH : TERM_LOG + 1;
	localparam int HALF_W = TERM_LOG / 2;
	localparam int PT_W   = GAIN_W + ERR_W;
	localparam int DT_W   = GAIN_W + DIFF_W;
	localparam int PD_W   = DT_W + 1;
	localparam int IP_W   = GAIN_W + HALF_W;
	localparam int IS_W   = 2 * HALF_W + GAIN_W;
	localparam int IT_W   = TERM_LOG + 2;
	localparam int U_W    = IT_W + 1;
	localparam int UC_W   = $clog2(OUT_LIM) + 1;
	localparam int PV_W   = UC_W + 1;

	localparam logic [IS_W-1:0]       TERM_LIM_C = IS_W'(1) << TERM_LOG;
	localparam logic signed [U_W-1:0] U_HI = U_W'(OUT_LIM);
	localparam logic signed [U_W-1:0] U_LO = -U_HI;
	localparam logic signed [UC_W-1:0] UC_HI = UC_W'(OUT_LIM);
	localparam logic [PV_W-1:0]       PV_OFS = PV_W'(PWM_OFS);
	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	// joint state
	logic signed [ANGLE_W-1:0]   meas_q, tgt_q;
	logic signed [ERR_W-1:0]     last_q;
	logic signed [SUM_WIDTH-1:0] sum_q;

	// encoder scaling
	logic [VAL_W-1:0]  mag_w;
	logic [XW-1:0]     x_w, x_s1, q_w, q_s2;
	logic [PROD_W-1:0] prod_w;
	value_t            val_s1, val_s2;
	logic signed [ANGLE_W-1:0] angle_w;

	// tick
	logic signed [ERR_W-1:0]     e_w, e_s3;
	logic signed [DIFF_W-1:0]    d_w, d_s3;
	logic signed [SUM_WIDTH:0]   sx_w;
	logic signed [SUM_WIDTH-1:0] sum_w, sum_s3;

	// terms
	logic [GAIN_W-1:0]        ki_mag_w;
	logic [MAGW-1:0]          sum_ext_w, smag_w;
	logic signed [PT_W-1:0]   p_s4;
	logic signed [DT_W-1:0]   d_s4;
	logic [IP_W-1:0]          ilo_s4, ihi_s4;
	logic                     ineg_s4, ibig_s4;
	logic [IS_W-1:0]          ip_w;
	logic [TERM_LOG:0]        imag_w;
	logic signed [IT_W-1:0]   t_s5;
	logic signed [PD_W-1:0]   pd_s5;
	logic signed [U_W-1:0]    u_w;
	logic signed [UC_W-1:0]   uc_w;
	logic [PV_W-1:0]          pv_w;
	logic                     over_w, under_w;

	assign mag_w  = value[VAL_W-1] ? VAL_W'(-value) : VAL_W'(value);
	assign x_w    = XW'(mag_w) * MUL_C + HALF_C;
	assign prod_w = PROD_W'(x_s1) * PROD_W'(RECIP_C);
	assign q_w    = XW'(prod_w >> SH);

	always_comb begin
		if (!val_s2[VAL_W-1]) begin
			angle_w = (q_s2 > QPOS_C) ? ANGLE_W'(ANGLE_MAX) : q_s2[ANGLE_W-1:0];
		end else begin
			angle_w = (q_s2 > QNEG_C) ? ANGLE_W'(-ANGLE_NEG) : -q_s2[ANGLE_W-1:0];
		end
	end

	assign e_w  = ERR_W'(tgt_q) - ERR_W'(meas_q);
	assign d_w  = DIFF_W'(e_w) - DIFF_W'(last_q);
	assign sx_w = (SUM_WIDTH + 1)'(sum_q) + (SUM_WIDTH + 1)'(e_w);

	always_comb begin
		if (sx_w[SUM_WIDTH] != sx_w[SUM_WIDTH-1]) begin
			sum_w = sx_w[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_w = sx_w[SUM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q <= '0;
			tgt_q  <= '0;
			last_q <= '0;
			sum_q  <= '0;
		end else begin
			if (ctl.upd_enc) begin
				meas_q <= angle_w;
			end
			if (ctl.upd_ref) begin
				tgt_q <= ANGLE_W'(val_s2);
			end
			if (ctl.upd_tick) begin
				last_q <= e_w;
				sum_q  <= sum_w;
			end
		end
	end

	assign ki_mag_w  = ki[GAIN_W-1] ? GAIN_W'(-ki) : GAIN_W'(ki);
	assign sum_ext_w = MAGW'(sum_s3);
	assign smag_w    = sum_s3[SUM_WIDTH-1] ? (~sum_ext_w + MAGW'(1)) : sum_ext_w;

	assign ip_w   = {ihi_s4, {HALF_W{1'b0}}} + IS_W'(ilo_s4);
	assign imag_w = (ibig_s4 || (ip_w >= TERM_LIM_C)) ? TERM_LIM_C[TERM_LOG:0]
		: ip_w[TERM_LOG:0];

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			val_s1 <= value;
			x_s1   <= x_w;
		end
		if (ctl.ld2) begin
			val_s2 <= val_s1;
			q_s2   <= q_w;
		end
		if (ctl.upd_tick) begin
			e_s3   <= e_w;
			d_s3   <= d_w;
			sum_s3 <= sum_w;
		end
		if (ctl.ld4) begin
			p_s4    <= PT_W'(kp) * PT_W'(e_s3);
			d_s4    <= DT_W'(kd) * DT_W'(d_s3);
			ilo_s4  <= IP_W'(ki_mag_w) * IP_W'(smag_w[HALF_W-1:0]);
			ihi_s4  <= IP_W'(ki_mag_w) * IP_W'(smag_w[2*HALF_W-1:HALF_W]);
			ineg_s4 <= ki[GAIN_W-1] ^ sum_s3[SUM_WIDTH-1];
			ibig_s4 <= (|smag_w[MAGW-1:TERM_LOG]) && (ki_mag_w != '0);
		end
		if (ctl.ld5) begin
			t_s5  <= ineg_s4 ? -$signed(IT_W'(imag_w)) : $signed(IT_W'(imag_w));
			pd_s5 <= PD_W'(p_s4) + PD_W'(d_s4);
		end
	end

	assign u_w     = U_W'(t_s5) + U_W'(pd_s5);
	assign over_w  = (u_w > U_HI);
	assign under_w = (u_w < U_LO);

	always_comb begin
		if (over_w) begin
			uc_w = UC_HI;
		end else if (under_w) begin
			uc_w = -UC_HI;
		end else begin
			uc_w = u_w[UC_W-1:0];
		end
	end

	assign pv_w  = PV_W'(uc_w) + PV_OFS;
	assign pwm   = pv_w[PWM_SHIFT +: PWM_W];
	assign clamp = over_w || under_w;

endmodule

// File: hw/rtl/three_joint_pid_pwm.sv
// Three-joint PID controller with clamped PWM outputs: gain registers, three lanes, result merge.
// Path: a tick's result passes the lane registers s1 to s5 and then the result register.
// Throughput: one input item per cycle; the five-stage lane pipeline plus the result register
// holds several items in flight and only a stalled result register stops intake.
// Reset: gains return to their defaults and all joint state clears at once; no clearing pass.
// Depends on tjp_pkg, tjp_if, tjp_flow and tjp_lane.
module three_joint_pid_pwm #(
	parameter int SUM_WIDTH = tjp_pkg::SUM_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tjp_in_if.sink    din,
	tjp_out_if.source dout,
	tjp_cfg_if.sink   cfg
);
	import tjp_pkg::*;

	gain_reg_t prop_q, integ_q, deriv_q;
	ctl_t      ctl;
	value_t    val_w  [JOINT_CNT];
	pwm_t      pwm_w  [JOINT_CNT];
	logic [JOINT_CNT-1:0] clamp_w;
	pwm_t      pwm_q  [JOINT_CNT];
	logic [JOINT_CNT-1:0] flags_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= PROP_GAINS_RST;
			integ_q <= '0;
			deriv_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PROP:  prop_q  <= cfg.data;
				CFG_INTEG: integ_q <= cfg.data;
				CFG_DERIV: deriv_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	tjp_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_mode   (din.mode),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.ctl       (ctl)
	);

	assign val_w[0] = din.value_base;
	assign val_w[1] = din.value_shoulder;
	assign val_w[2] = din.value_elbow;

	for (genvar j = 0; j < JOINT_CNT; j++) begin : g_lane
		tjp_lane #(
			.SUM_WIDTH  (SUM_WIDTH),
			.SCALE_MUL  (SCALE_MUL_TAB[j]),
			.SCALE_DIV  (SCALE_DIV_TAB[j]),
			.SCALE_HALF (SCALE_HALF_TAB[j])
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.value  (val_w[j]),
			.kp     (prop_q[GAIN_W*j +: GAIN_W]),
			.ki     (integ_q[GAIN_W*j +: GAIN_W]),
			.kd     (deriv_q[GAIN_W*j +: GAIN_W]),
			.pwm    (pwm_w[j]),
			.clamp  (clamp_w[j])
		);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			pwm_q   <= pwm_w;
			flags_q <= clamp_w;
		end
	end

	assign dout.pwm_base     = pwm_q[0];
	assign dout.pwm_shoulder = pwm_q[1];
	assign dout.pwm_elbow    = pwm_q[2];
	assign dout.clamp_flags  = flags_q;

endmodule
